// ===== sv/normalized_edit_distance_similarity_assert.svh =====
// assertion macros shared by the rtl files
// each macro checks on the rising edge of clk and is off while rst_n is low
`ifndef NORMALIZED_EDIT_DISTANCE_SIMILARITY_ASSERT_SVH
`define NORMALIZED_EDIT_DISTANCE_SIMILARITY_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define NEDS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define NEDS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define NEDS_ASSERT_IMP(lbl, ante, cons, msg)

`define NEDS_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

// ===== sv/neds_pkg.sv =====
package neds_pkg;

    localparam int CHAR_W = 8;
    localparam int DIST_W = 7;
    localparam int SIM_W  = 17;

    localparam logic [SIM_W-1:0]  SIM_ONE      = 17'd65536;
    localparam logic [SIM_W-1:0]  SIM_ZERO     = 17'd0;
    localparam logic [SIM_W-1:0]  THRESH_RESET = 17'd22938;
    localparam logic [DIST_W-1:0] DIST_MAX     = 7'd127;

    // command codes
    localparam logic CMD_QUERY = 1'b0;
    localparam logic CMD_CAND  = 1'b1;

    // character classes
    localparam logic [CHAR_W-1:0] CH_UP_A     = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UP_Z     = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_LO_A     = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LO_Z     = 8'h7A;
    localparam logic [CHAR_W-1:0] CH_DIGIT_0  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_DIGIT_9  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_SPACE    = 8'h20;
    localparam logic [CHAR_W-1:0] CASE_OFFSET = 8'h20;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    typedef struct packed {
        logic              keep;
        logic [CHAR_W-1:0] ch;
    } norm_char_t;

    // lower-case A-Z, keep only letters, digits and space
    function automatic norm_char_t normalize(input logic [CHAR_W-1:0] raw);
        norm_char_t        r;
        logic [CHAR_W-1:0] c;
        c = raw;
        if (c >= CH_UP_A && c <= CH_UP_Z)
        begin
            c = c + CASE_OFFSET;
        end
        r.ch   = c;
        r.keep = (c >= CH_LO_A && c <= CH_LO_Z) ||
                 (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) ||
                 (c == CH_SPACE);
        return r;
    endfunction

endpackage

// ===== sv/neds_div.sv =====
`include "normalized_edit_distance_similarity_assert.svh"

module neds_div #(
    parameter int LW = 7
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [LW-1:0]              num_hi,
    input  logic [neds_pkg::SIM_W-1:0] num_lo,
    input  logic [LW:0]                divisor,
    output logic [neds_pkg::SIM_W-1:0] quotient,
    output neds_pkg::div_stat_t        stat
);

    import neds_pkg::*;

    localparam int CW = $clog2(SIM_W);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [LW:0]      rem_reg, rem_next;
    logic [LW:0]      div_reg, div_next;
    logic [SIM_W-1:0] lo_reg, lo_next;
    logic [SIM_W-1:0] quo_reg, quo_next;

    logic [LW+1:0]    trial;
    logic [LW+1:0]    rem_step;
    logic             ge;

    // restoring step: one quotient bit per cycle
    assign trial    = {rem_reg, lo_reg[SIM_W-1]};
    assign ge       = trial >= {1'b0, div_reg};
    assign rem_step = ge ? (trial - {1'b0, div_reg}) : trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        lo_next   = lo_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(SIM_W - 1);
            rem_next  = {1'b0, num_hi};
            div_next  = divisor;
            lo_next   = num_lo;
            quo_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next = rem_step[LW:0];
            lo_next  = {lo_reg[SIM_W-2:0], 1'b0};
            quo_next = {quo_reg[SIM_W-2:0], ge};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        div_reg <= div_next;
        lo_reg  <= lo_next;
        quo_reg <= quo_next;
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

    `NEDS_ASSERT_IMP(a_rem_below_div, busy_reg, rem_reg < div_reg, "remainder reached divisor")
    `NEDS_ASSERT_IMP(a_start_idle, start, !busy_reg, "divider restarted while busy")
    `NEDS_ASSERT_NXT(a_start_busy, start, busy_reg, "divider did not start")

endmodule

// ===== sv/normalized_edit_distance_similarity.sv =====
// Normalized edit-distance similarity. Query and candidate strings arrive one
// byte per beat on the input channel (command 0 = query, 1 = candidate); each
// byte is lower-cased and kept only if it is a letter, digit or space, and up
// to MAX_LEN kept bytes per string are stored (more sets the truncated flag).
// Loading takes one beat per cycle while the input is not stalled. The query
// stays stored for any number of candidates. The candidate's last byte starts
// the compute: the Levenshtein matrix is walked one cell per cycle through a
// row memory (read, update, write back, with a forward path for back-to-back
// rows), followed by a bit-serial divide for the Q1.16 score; if either string
// is empty, the matrix and the divide are skipped. The input is stalled during
// the compute and while a result waits for the output register. One result
// waiting on a stalled output does not block loading of the next strings.
// The match threshold can be written at any time through cfg_we / cfg_data and
// resets to 0.35 in Q1.16.
`include "normalized_edit_distance_similarity_assert.svh"

module normalized_edit_distance_similarity #(
    parameter int MAX_LEN = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // input channel
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        command,
    input  logic [neds_pkg::CHAR_W-1:0] char_byte,
    input  logic                        last_char,
    input  logic                        empty_string,
    // result channel
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [neds_pkg::DIST_W-1:0] edit_distance,
    output logic [neds_pkg::SIM_W-1:0]  similarity,
    output logic                        above_threshold,
    output logic                        truncated,
    // threshold register
    input  logic                        cfg_we,
    input  logic [neds_pkg::SIM_W-1:0]  cfg_data
);

    import neds_pkg::*;

    localparam int LW  = $clog2(MAX_LEN + 1);     // lengths and distances
    localparam int IW  = $clog2(MAX_LEN);         // index into one string
    localparam int SAW = $clog2(2 * MAX_LEN);     // string memory address
    localparam int XW  = (LW > DIST_W) ? LW : DIST_W;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_LEV  = 4'b0010,
        S_DIV  = 4'b0100,
        S_OUT  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    // string memory: query at the bottom, candidate from MAX_LEN up
    logic [CHAR_W-1:0] str_mem [0:2*MAX_LEN-1];
    logic              str_we;
    logic [SAW-1:0]    str_waddr;
    logic [SAW-1:0]    q_raddr;
    logic [SAW-1:0]    c_raddr;
    logic [CHAR_W-1:0] q_rd_reg;
    logic [CHAR_W-1:0] c_rd_reg;

    // one matrix row, entry j-1 holds cell j
    logic [LW-1:0]     row_mem [0:MAX_LEN-1];
    logic              row_we;
    logic [IW-1:0]     row_waddr;
    logic [IW-1:0]     row_raddr;
    logic [LW-1:0]     row_rd_reg;

    // configuration
    logic [SIM_W-1:0]  thresh_reg, thresh_next;

    // string bookkeeping
    logic [LW-1:0]     q_len_reg, q_len_next;
    logic              q_over_reg, q_over_next;
    logic              q_done_reg, q_done_next;
    logic [LW-1:0]     c_len_reg, c_len_next;
    logic              c_over_reg, c_over_next;

    // job captured at candidate end
    logic [LW-1:0]     m_reg, m_next;
    logic [LW-1:0]     n_reg, n_next;
    logic [LW-1:0]     maxl_reg, maxl_next;
    logic              trunc_reg, trunc_next;

    // cell walk, stage a issues reads, stage b updates
    logic              a_valid_reg, a_valid_next;
    logic [LW-1:0]     a_i_reg, a_i_next;
    logic [LW-1:0]     a_j_reg, a_j_next;
    logic              b_valid_reg, b_valid_next;
    logic [LW-1:0]     b_i_reg, b_i_next;
    logic [LW-1:0]     b_j_reg, b_j_next;
    logic              b_first_reg, b_first_next;
    logic              b_last_reg, b_last_next;
    logic              fwd_hit_reg, fwd_hit_next;
    logic [LW-1:0]     fwd_data_reg, fwd_data_next;
    logic [LW-1:0]     left_reg, left_next;
    logic [LW-1:0]     diag_reg, diag_next;

    // results
    logic [LW-1:0]     dist_reg, dist_next;
    logic [SIM_W-1:0]  sim_reg, sim_next;
    logic              div_go_reg, div_go_next;

    // output register
    logic              out_valid_reg, out_valid_next;
    logic [DIST_W-1:0] edit_distance_reg, edit_distance_next;
    logic [SIM_W-1:0]  similarity_reg, similarity_next;
    logic              above_threshold_reg, above_threshold_next;
    logic              truncated_reg, truncated_next;

    // helpers
    norm_char_t        nc;
    logic              in_acc;
    logic              q_restart;
    logic [LW-1:0]     q_base;
    logic [LW-1:0]     n_fin;
    logic              over_fin;
    logic [LW-1:0]     maxl_fin;
    logic [LW-1:0]     a_im1;
    logic [LW-1:0]     a_jm1;
    logic [LW-1:0]     b_jm1;
    logic [LW-1:0]     prev_j;
    logic [LW-1:0]     left_v;
    logic [LW-1:0]     diag_v;
    logic [LW:0]       up_sum;
    logic [LW:0]       left_sum;
    logic [LW:0]       diag_sum;
    logic [LW:0]       best_w;
    logic [LW-1:0]     cell_best;
    logic [XW-1:0]     dist_x;
    logic [DIST_W-1:0] dist_sat;

    // divider
    logic [SIM_W-1:0]  div_quot;
    div_stat_t         div_stat;

    assign in_stall = (state_reg != S_IDLE);
    assign in_acc   = in_valid && !in_stall;
    assign nc       = normalize(char_byte);

    assign q_restart = empty_string || q_done_reg;
    assign q_base    = q_restart ? '0 : q_len_reg;

    // read addresses for the cell in stage a
    assign a_im1     = a_i_reg - LW'(1);
    assign a_jm1     = a_j_reg - LW'(1);
    assign b_jm1     = b_j_reg - LW'(1);
    assign q_raddr   = SAW'(a_im1);
    assign c_raddr   = SAW'(MAX_LEN) + SAW'(a_jm1);
    assign row_raddr = a_jm1[IW-1:0];
    assign row_waddr = b_jm1[IW-1:0];
    assign row_we    = b_valid_reg;

    // cell update: first row comes from the index, a write to the same cell in the
    // previous cycle comes from the forward register
    assign prev_j   = (b_i_reg == LW'(1)) ? b_j_reg :
                      (fwd_hit_reg ? fwd_data_reg : row_rd_reg);
    assign left_v   = b_first_reg ? b_i_reg : left_reg;
    assign diag_v   = b_first_reg ? (b_i_reg - LW'(1)) : diag_reg;
    assign up_sum   = {1'b0, prev_j} + (LW+1)'(1);
    assign left_sum = {1'b0, left_v} + (LW+1)'(1);
    assign diag_sum = {1'b0, diag_v} + (LW+1)'(q_rd_reg != c_rd_reg);

    always_comb
    begin
        best_w = up_sum;
        if (left_sum < best_w)
        begin
            best_w = left_sum;
        end
        if (diag_sum < best_w)
        begin
            best_w = diag_sum;
        end
    end

    assign cell_best = best_w[LW-1:0];

    // distance saturates at the width of the result field
    assign dist_x   = XW'(dist_reg);
    assign dist_sat = (dist_x > XW'(DIST_MAX)) ? DIST_MAX : dist_x[DIST_W-1:0];

    always_comb
    begin
        state_next           = state_reg;
        thresh_next          = cfg_we ? cfg_data : thresh_reg;
        q_len_next           = q_len_reg;
        q_over_next          = q_over_reg;
        q_done_next          = q_done_reg;
        c_len_next           = c_len_reg;
        c_over_next          = c_over_reg;
        m_next               = m_reg;
        n_next               = n_reg;
        maxl_next            = maxl_reg;
        trunc_next           = trunc_reg;
        dist_next            = dist_reg;
        sim_next             = sim_reg;
        div_go_next          = 1'b0;
        str_we               = 1'b0;
        str_waddr            = '0;
        n_fin                = c_len_reg;
        over_fin             = c_over_reg;
        maxl_fin             = '0;
        out_valid_next       = out_valid_reg;
        edit_distance_next   = edit_distance_reg;
        similarity_next      = similarity_reg;
        above_threshold_next = above_threshold_reg;
        truncated_next       = truncated_reg;

        // cell walk, row by row
        a_valid_next  = a_valid_reg;
        a_i_next      = a_i_reg;
        a_j_next      = a_j_reg;
        b_valid_next  = a_valid_reg;
        b_i_next      = a_i_reg;
        b_j_next      = a_j_reg;
        b_first_next  = (a_j_reg == LW'(1));
        b_last_next   = (a_i_reg == m_reg) && (a_j_reg == n_reg);
        fwd_hit_next  = b_valid_reg && a_valid_reg && (a_j_reg == b_j_reg);
        fwd_data_next = cell_best;
        left_next     = b_valid_reg ? cell_best : left_reg;
        diag_next     = b_valid_reg ? prev_j : diag_reg;
        if (a_valid_reg)
        begin
            if (a_j_reg == n_reg)
            begin
                a_j_next = LW'(1);
                a_i_next = a_i_reg + LW'(1);
                if (a_i_reg == m_reg)
                begin
                    a_valid_next = 1'b0;
                end
            end
            else
            begin
                a_j_next = a_j_reg + LW'(1);
            end
        end

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    if (command == CMD_QUERY)
                    begin
                        // a finished query is replaced by the next query beat
                        q_len_next  = q_base;
                        q_over_next = q_restart ? 1'b0 : q_over_reg;
                        q_done_next = empty_string ? 1'b1 : last_char;
                        if (!empty_string && nc.keep)
                        begin
                            if (q_base < LW'(MAX_LEN))
                            begin
                                str_we     = 1'b1;
                                str_waddr  = SAW'(q_base);
                                q_len_next = q_base + LW'(1);
                            end
                            else
                            begin
                                q_over_next = 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        if (empty_string)
                        begin
                            n_fin    = '0;
                            over_fin = 1'b0;
                        end
                        else if (nc.keep)
                        begin
                            if (c_len_reg < LW'(MAX_LEN))
                            begin
                                str_we    = 1'b1;
                                str_waddr = SAW'(MAX_LEN) + SAW'(c_len_reg);
                                n_fin     = c_len_reg + LW'(1);
                            end
                            else
                            begin
                                over_fin = 1'b1;
                            end
                        end
                        c_len_next  = n_fin;
                        c_over_next = over_fin;
                        maxl_fin    = (q_len_reg > n_fin) ? q_len_reg : n_fin;
                        if (empty_string || last_char)
                        begin
                            // candidate ends: capture the job, clear candidate
                            c_len_next  = '0;
                            c_over_next = 1'b0;
                            m_next      = q_len_reg;
                            n_next      = n_fin;
                            maxl_next   = maxl_fin;
                            trunc_next  = q_over_reg || over_fin;
                            if (q_len_reg == '0 || n_fin == '0)
                            begin
                                // an empty side needs no matrix
                                dist_next  = maxl_fin;
                                sim_next   = (q_len_reg == n_fin) ? SIM_ONE : SIM_ZERO;
                                state_next = S_OUT;
                            end
                            else
                            begin
                                a_valid_next = 1'b1;
                                a_i_next     = LW'(1);
                                a_j_next     = LW'(1);
                                state_next   = S_LEV;
                            end
                        end
                    end
                end
            end
            S_LEV:
            begin
                if (b_valid_reg && b_last_reg)
                begin
                    dist_next   = cell_best;
                    div_go_next = 1'b1;
                    state_next  = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_stat.done)
                begin
                    sim_next   = div_quot;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                // output register free or being emptied this cycle
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next       = 1'b1;
                    edit_distance_next   = dist_sat;
                    similarity_next      = sim_reg;
                    above_threshold_next = sim_reg > thresh_reg;
                    truncated_next       = trunc_reg;
                    state_next           = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // score = ((maxl - d) * 2^17 + maxl) / (2 * maxl)
    neds_div #(
        .LW (LW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_go_reg),
        .num_hi   (maxl_reg - dist_reg),
        .num_lo   (SIM_W'(maxl_reg)),
        .divisor  ({maxl_reg, 1'b0}),
        .quotient (div_quot),
        .stat     (div_stat)
    );

    // memories
    always_ff @(posedge clk)
    begin
        if (str_we)
        begin
            str_mem[str_waddr] <= nc.ch;
        end
        q_rd_reg <= str_mem[q_raddr];
        c_rd_reg <= str_mem[c_raddr];
        if (row_we)
        begin
            row_mem[row_waddr] <= cell_best;
        end
        row_rd_reg <= row_mem[row_raddr];
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            thresh_reg    <= THRESH_RESET;
            q_len_reg     <= '0;
            q_over_reg    <= 1'b0;
            q_done_reg    <= 1'b0;
            c_len_reg     <= '0;
            c_over_reg    <= 1'b0;
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            fwd_hit_reg   <= 1'b0;
            div_go_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            thresh_reg    <= thresh_next;
            q_len_reg     <= q_len_next;
            q_over_reg    <= q_over_next;
            q_done_reg    <= q_done_next;
            c_len_reg     <= c_len_next;
            c_over_reg    <= c_over_next;
            a_valid_reg   <= a_valid_next;
            b_valid_reg   <= b_valid_next;
            fwd_hit_reg   <= fwd_hit_next;
            div_go_reg    <= div_go_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        m_reg               <= m_next;
        n_reg               <= n_next;
        maxl_reg            <= maxl_next;
        trunc_reg           <= trunc_next;
        a_i_reg             <= a_i_next;
        a_j_reg             <= a_j_next;
        b_i_reg             <= b_i_next;
        b_j_reg             <= b_j_next;
        b_first_reg         <= b_first_next;
        b_last_reg          <= b_last_next;
        fwd_data_reg        <= fwd_data_next;
        left_reg            <= left_next;
        diag_reg            <= diag_next;
        dist_reg            <= dist_next;
        sim_reg             <= sim_next;
        edit_distance_reg   <= edit_distance_next;
        similarity_reg      <= similarity_next;
        above_threshold_reg <= above_threshold_next;
        truncated_reg       <= truncated_next;
    end

    assign out_valid       = out_valid_reg;
    assign edit_distance   = edit_distance_reg;
    assign similarity      = similarity_reg;
    assign above_threshold = above_threshold_reg;
    assign truncated       = truncated_reg;

    `NEDS_ASSERT_IMP(a_cell_in_lev, b_valid_reg, state_reg == S_LEV, "cell update outside compute")
    `NEDS_ASSERT_IMP(a_fwd_has_cell, fwd_hit_reg, b_valid_reg, "forward hit with no cell")
    `NEDS_ASSERT_IMP(a_len_bound, 1'b1, (q_len_reg <= LW'(MAX_LEN)) && (c_len_reg <= LW'(MAX_LEN)), "length past limit")
    `NEDS_ASSERT_IMP(a_zero_dist_full, out_valid_reg && (edit_distance_reg == '0), similarity_reg == SIM_ONE, "zero distance without full score")

endmodule

// ===== sim/tb_top.sv =====
module tb_top;
    import neds_pkg::*;

    localparam int MAX_LEN     = 64;
    localparam int SETTLE_WAIT = 30;    // cycles past the last result before a register write
    localparam int DRAIN_WAIT  = 100;   // cycles past the last result at the end of the run
    localparam int PHASE_BEATS = 330;   // random beats per threshold setting
    localparam int HOLD_AT     = 500;   // beats sent before the long receiver hold-off
    localparam int HOLD_CYCLES = 2500;

    // one input beat
    typedef struct packed {
        logic              command;
        logic [CHAR_W-1:0] char_byte;
        logic              last_char;
        logic              empty_string;
    } char_beat_t;

    // one result beat
    typedef struct packed {
        logic [DIST_W-1:0] edit_distance;
        logic [SIM_W-1:0]  similarity;
        logic              above_threshold;
        logic              truncated;
    } score_t;

    // directed stimulus row, with the score typed in where it is obvious
    typedef struct {
        char_beat_t beat;
        logic       fixed;
        score_t     score;
    } stim_row_t;

    typedef logic [CHAR_W-1:0] byte_q_t[$];

    typedef enum int {RX_OPEN, RX_RANDOM, RX_PATTERN, RX_HOLD} rx_mode_e;

    logic              clk;
    logic              rst_n        = 1'b0;
    logic              in_valid     = 1'b0;
    logic              in_stall;
    logic              command      = CMD_QUERY;
    logic [CHAR_W-1:0] char_byte    = '0;
    logic              last_char    = 1'b0;
    logic              empty_string = 1'b0;
    logic              out_valid;
    logic              out_stall    = 1'b0;
    logic [DIST_W-1:0] edit_distance;
    logic [SIM_W-1:0]  similarity;
    logic              above_threshold;
    logic              truncated;
    logic              cfg_we       = 1'b0;
    logic [SIM_W-1:0]  cfg_data     = '0;

    // scoreboard
    score_t    expected_scores[$];
    stim_row_t directed_rows[$];
    int        beats_sent  = 0;
    int        scores_seen = 0;
    int        mismatches  = 0;
    int        burst_left  = 0;

    // predictor state
    logic [CHAR_W-1:0] query_chars [MAX_LEN];
    logic [CHAR_W-1:0] cand_chars  [MAX_LEN];
    int                query_len       = 0;
    int                cand_len        = 0;
    logic              query_done      = 1'b0;
    logic              query_over      = 1'b0;
    logic              cand_over       = 1'b0;
    logic [SIM_W-1:0]  threshold_model = THRESH_RESET;

    // raw bytes of the latest generated query, used to build near matches
    byte_q_t last_query_text;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    normalized_edit_distance_similarity #(
        .MAX_LEN(MAX_LEN)
    ) i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .command         (command),
        .char_byte       (char_byte),
        .last_char       (last_char),
        .empty_string    (empty_string),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .edit_distance   (edit_distance),
        .similarity      (similarity),
        .above_threshold (above_threshold),
        .truncated       (truncated),
        .cfg_we          (cfg_we),
        .cfg_data        (cfg_data)
    );

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // fold upper case onto lower case, report whether the byte is kept
    function automatic logic fold_char(input logic [CHAR_W-1:0] raw,
                                       output logic [CHAR_W-1:0] ch);
        logic [CHAR_W-1:0] c;
        c = raw;
        if (c >= CH_UP_A && c <= CH_UP_Z)
        begin
            c = c + CASE_OFFSET;
        end
        ch = c;
        return (c >= CH_LO_A && c <= CH_LO_Z) || (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) ||
               (c == CH_SPACE);
    endfunction

    // two-row levenshtein over the stored strings
    function automatic int edit_cost();
        int prev [0:MAX_LEN];
        int cur  [0:MAX_LEN];
        int i;
        int j;
        int cost;
        int best;
        for (j = 0; j <= cand_len; j++)
        begin
            prev[j] = j;
            cur[j]  = j;
        end
        for (i = 1; i <= query_len; i++)
        begin
            cur[0] = i;
            for (j = 1; j <= cand_len; j++)
            begin
                cost = (query_chars[i-1] == cand_chars[j-1]) ? 0 : 1;
                best = prev[j] + 1;
                if (cur[j-1] + 1 < best)
                begin
                    best = cur[j-1] + 1;
                end
                if (prev[j-1] + cost < best)
                begin
                    best = prev[j-1] + cost;
                end
                cur[j] = best;
            end
            prev = cur;
        end
        return prev[cand_len];
    endfunction

    // result of a finished candidate; clears the candidate afterwards
    function automatic score_t score_candidate();
        score_t r;
        int     d;
        int     sim;
        int     longest;
        int     k;
        logic   same;
        longest = (query_len > cand_len) ? query_len : cand_len;
        same    = (query_len == cand_len);
        for (k = 0; k < query_len; k++)
        begin
            if (same && query_chars[k] != cand_chars[k])
            begin
                same = 1'b0;
            end
        end
        if (same)
        begin
            d   = 0;
            sim = int'(SIM_ONE);
        end
        else if (query_len == 0 || cand_len == 0)
        begin
            d   = longest;
            sim = int'(SIM_ZERO);
        end
        else
        begin
            d   = edit_cost();
            // q1.16 with round to nearest, ties up
            sim = ((longest - d) * 131072 + longest) / (2 * longest);
        end
        if (d > int'(DIST_MAX))
        begin
            d = int'(DIST_MAX);
        end
        r.edit_distance   = DIST_W'(d);
        r.similarity      = SIM_W'(sim);
        r.above_threshold = (sim > int'(threshold_model));
        r.truncated       = query_over || cand_over;
        cand_len  = 0;
        cand_over = 1'b0;
        return r;
    endfunction

    // update the model with one accepted beat; returns 1 when a result is due
    function automatic logic apply_beat(input char_beat_t b, output score_t s);
        logic              keep;
        logic [CHAR_W-1:0] ch;
        s    = '0;
        keep = fold_char(b.char_byte, ch);
        if (b.command == CMD_QUERY)
        begin
            // a query beat after a finished query starts a new one
            if (b.empty_string || query_done)
            begin
                query_len  = 0;
                query_over = 1'b0;
                query_done = 1'b0;
            end
            if (b.empty_string)
            begin
                query_done = 1'b1;
                return 1'b0;
            end
            if (keep)
            begin
                if (query_len < MAX_LEN)
                begin
                    query_chars[query_len] = ch;
                    query_len++;
                end
                else
                begin
                    query_over = 1'b1;
                end
            end
            if (b.last_char)
            begin
                query_done = 1'b1;
            end
            return 1'b0;
        end
        // empty candidate drops anything already sent for it
        if (b.empty_string)
        begin
            cand_len  = 0;
            cand_over = 1'b0;
            s = score_candidate();
            return 1'b1;
        end
        if (keep)
        begin
            if (cand_len < MAX_LEN)
            begin
                cand_chars[cand_len] = ch;
                cand_len++;
            end
            else
            begin
                cand_over = 1'b1;
            end
        end
        if (!b.last_char)
        begin
            return 1'b0;
        end
        s = score_candidate();
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // small alphabet so that distances stay interesting
    function automatic logic [CHAR_W-1:0] pick_char();
        int r;
        r = $urandom_range(0, 19);
        if (r < 3)
        begin
            return CHAR_W'($urandom_range(0, 255));   // any byte, mostly dropped
        end
        if (r < 6)
        begin
            return CH_UP_A + CHAR_W'($urandom_range(0, 2));
        end
        if (r < 8)
        begin
            return CH_SPACE;
        end
        if (r < 10)
        begin
            return CH_DIGIT_0 + CHAR_W'(1);
        end
        return CH_LO_A + CHAR_W'($urandom_range(0, 2));
    endfunction

    // mostly short strings, a few past MAX_LEN
    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
        begin
            return 0;
        end
        if (r < 85)
        begin
            return $urandom_range(1, 8);
        end
        if (r < 96)
        begin
            return $urandom_range(9, 24);
        end
        return $urandom_range(40, 70);
    endfunction

    function automatic byte_q_t random_text(input int len);
        byte_q_t q;
        int      k;
        for (k = 0; k < len; k++)
        begin
            q.push_back(pick_char());
        end
        return q;
    endfunction

    // up to two edits away from the source
    function automatic byte_q_t near_text(input byte_q_t src);
        byte_q_t q;
        int      k;
        int      pos;
        int      edits;
        q     = src;
        edits = $urandom_range(0, 2);
        for (k = 0; k < edits; k++)
        begin
            pos = (q.size() == 0) ? 0 : $urandom_range(0, q.size() - 1);
            case ($urandom_range(0, 2))
                0:
                begin
                    if (q.size() != 0)
                    begin
                        q[pos] = pick_char();
                    end
                end
                1:
                begin
                    q.insert(pos, pick_char());
                end
                default:
                begin
                    if (q.size() != 0)
                    begin
                        q.delete(pos);
                    end
                end
            endcase
        end
        return q;
    endfunction

    // offer one beat after a random gap, wait for it to be taken, then predict
    task automatic send_beat(input char_beat_t b, input logic fixed, input score_t fixed_score);
        score_t predicted;
        int     gap;
        @(negedge clk);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        in_valid     <= 1'b1;
        command      <= b.command;
        char_byte    <= b.char_byte;
        last_char    <= b.last_char;
        empty_string <= b.empty_string;
        @(posedge clk);
        while (in_stall !== 1'b0)
        begin
            @(posedge clk);
        end
        beats_sent++;
        if (apply_beat(b, predicted))
        begin
            expected_scores.push_back(fixed ? fixed_score : predicted);
        end
    endtask

    // one string; an empty text becomes an empty_string beat,
    // and now and then a string is broken off by an empty_string beat
    task automatic send_text(input logic cmd, input byte_q_t text, input logic close);
        char_beat_t b;
        score_t     no_score;
        int         k;
        no_score  = '0;
        b.command = cmd;
        if (text.size() == 0)
        begin
            b.char_byte    = CHAR_W'($urandom_range(0, 255));
            b.last_char    = 1'($urandom_range(0, 1));
            b.empty_string = 1'b1;
            send_beat(b, 1'b0, no_score);
            return;
        end
        for (k = 0; k < text.size(); k++)
        begin
            b.char_byte    = text[k];
            b.last_char    = close && (k == text.size() - 1);
            b.empty_string = 1'b0;
            if (k != 0 && $urandom_range(0, 59) == 0)
            begin
                b.empty_string = 1'b1;
                b.last_char    = 1'($urandom_range(0, 1));
                send_beat(b, 1'b0, no_score);
                return;
            end
            send_beat(b, 1'b0, no_score);
        end
    endtask

    // drop valid, wait for every result and then some quiet cycles
    task automatic settle(input int extra);
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_scores.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (extra) @(posedge clk);
    endtask

    task automatic set_threshold(input logic [SIM_W-1:0] value);
        settle(SETTLE_WAIT);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(negedge clk);
        cfg_we   <= 1'b0;
        threshold_model = value;
    endtask

    task automatic add_row(input logic cmd, input logic [CHAR_W-1:0] ch, input logic last,
                           input logic empty, input logic fixed, input int d, input int sim,
                           input logic above, input logic trunc);
        stim_row_t row;
        row.beat.command             = cmd;
        row.beat.char_byte           = ch;
        row.beat.last_char           = last;
        row.beat.empty_string        = empty;
        row.fixed                    = fixed;
        row.score.edit_distance      = DIST_W'(d);
        row.score.similarity         = SIM_W'(sim);
        row.score.above_threshold    = above;
        row.score.truncated          = trunc;
        directed_rows.push_back(row);
    endtask

    // random traffic: new queries, candidates near the query, random candidates,
    // and candidates that arrive while the query is still open
    task automatic run_phase(input int n_beats);
        int      start;
        int      r;
        byte_q_t text;
        start = beats_sent;
        while (beats_sent - start < n_beats)
        begin
            r = $urandom_range(0, 99);
            if (r < 20)
            begin
                last_query_text = random_text(pick_len());
                send_text(CMD_QUERY, last_query_text, 1'b1);
            end
            else if (r < 28)
            begin
                // open query, candidate against the partial query, then close it
                text = random_text($urandom_range(1, 3));
                send_text(CMD_QUERY, text, 1'b0);
                send_text(CMD_CAND, near_text(text), 1'b1);
                text = random_text($urandom_range(1, 3));
                send_text(CMD_QUERY, text, 1'b1);
                last_query_text = {};
            end
            else if (r < 60)
            begin
                send_text(CMD_CAND, near_text(last_query_text), 1'b1);
            end
            else
            begin
                send_text(CMD_CAND, random_text(pick_len()), 1'b1);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // result checker
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : result_check
        score_t want;
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (expected_scores.size() == 0)
            begin
                $error("result beat with no expected result waiting");
                mismatches++;
            end
            else
            begin
                want = expected_scores.pop_front();
                scores_seen++;
                if (edit_distance !== want.edit_distance)
                begin
                    $error("edit_distance expected %0d actual %0d",
                           want.edit_distance, edit_distance);
                    mismatches++;
                end
                if (similarity !== want.similarity)
                begin
                    $error("similarity expected %0d actual %0d", want.similarity, similarity);
                    mismatches++;
                end
                if (above_threshold !== want.above_threshold)
                begin
                    $error("above_threshold expected %0d actual %0d",
                           want.above_threshold, above_threshold);
                    mismatches++;
                end
                if (truncated !== want.truncated)
                begin
                    $error("truncated expected %0d actual %0d", want.truncated, truncated);
                    mismatches++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver: stall segments of random style, plus one long hold-off
    // while the sender keeps pushing so the block backs up into its input
    // ------------------------------------------------------------------
    initial
    begin : receiver
        rx_mode_e mode;
        int       seg;
        int       k;
        logic     hold_done;
        hold_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            mode = rx_mode_e'($urandom_range(0, 2));
            seg  = $urandom_range(20, 300);
            for (k = 0; k < seg; k++)
            begin
                if (!hold_done && beats_sent >= HOLD_AT)
                begin
                    hold_done = 1'b1;
                    mode      = RX_HOLD;
                    seg       = k + HOLD_CYCLES;
                end
                @(negedge clk);
                case (mode)
                    RX_OPEN:    out_stall <= 1'b0;
                    RX_RANDOM:  out_stall <= 1'($urandom_range(0, 1));
                    RX_PATTERN: out_stall <= (k % 4 != 0);
                    default:    out_stall <= 1'b1;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin : main_seq
        logic [SIM_W-1:0] phase_thresholds [6];
        int               p;

        // threshold settings for the random phases, extremes included
        phase_thresholds[0] = '0;
        phase_thresholds[1] = SIM_ONE;
        phase_thresholds[2] = SIM_W'(32768);    // equals the score of one edit in two
        phase_thresholds[3] = SIM_ONE - SIM_W'(1);
        phase_thresholds[4] = SIM_W'($urandom_range(1, 65534));
        phase_thresholds[5] = THRESH_RESET;

        // directed rows, run with the reset threshold
        // both empty: equal strings
        add_row(CMD_QUERY, 8'h00, 1'b0, 1'b1, 1'b0, 0, 0, 1'b0, 1'b0);
        add_row(CMD_CAND,  8'hFF, 1'b0, 1'b1, 1'b1, 0, 65536, 1'b1, 1'b0);
        // query "a", closed by a dropped byte
        add_row(CMD_QUERY, 8'h41, 1'b0, 1'b0, 1'b0, 0, 0, 1'b0, 1'b0);
        add_row(CMD_QUERY, 8'h21, 1'b1, 1'b0, 1'b0, 0, 0, 1'b0, 1'b0);
        add_row(CMD_CAND,  8'h61, 1'b1, 1'b0, 1'b1, 0, 65536, 1'b1, 1'b0);
        // empty candidate against a one-byte query
        add_row(CMD_CAND,  8'h7A, 1'b1, 1'b1, 1'b1, 1, 0, 1'b0, 1'b0);
        // "z9" with a dropped byte in front
        add_row(CMD_CAND,  8'hFF, 1'b0, 1'b0, 1'b0, 0, 0, 1'b0, 1'b0);
        add_row(CMD_CAND,  8'h5A, 1'b0, 1'b0, 1'b0, 0, 0, 1'b0, 1'b0);
        add_row(CMD_CAND,  8'h39, 1'b1, 1'b0, 1'b0, 0, 0, 1'b0, 1'b0);
        // empty flag without last_char still ends the candidate
        add_row(CMD_CAND,  8'h20, 1'b0, 1'b1, 1'b1, 1, 0, 1'b0, 1'b0);
        // candidate made only of a dropped final byte
        add_row(CMD_CAND,  8'h00, 1'b1, 1'b0, 1'b1, 1, 0, 1'b0, 1'b0);
        // new query left open, candidate compared with the partial query
        add_row(CMD_QUERY, 8'h30, 1'b0, 1'b0, 1'b0, 0, 0, 1'b0, 1'b0);
        add_row(CMD_CAND,  8'h80, 1'b0, 1'b0, 1'b0, 0, 0, 1'b0, 1'b0);
        add_row(CMD_CAND,  8'h78, 1'b1, 1'b0, 1'b0, 0, 0, 1'b0, 1'b0);
        add_row(CMD_QUERY, 8'h7A, 1'b1, 1'b0, 1'b0, 0, 0, 1'b0, 1'b0);
        // exact match of "0z", then one deletion
        add_row(CMD_CAND,  8'h30, 1'b0, 1'b0, 1'b0, 0, 0, 1'b0, 1'b0);
        add_row(CMD_CAND,  8'h5A, 1'b1, 1'b0, 1'b1, 0, 65536, 1'b1, 1'b0);
        add_row(CMD_CAND,  8'h30, 1'b1, 1'b0, 1'b0, 0, 0, 1'b0, 1'b0);
        // query of bytes just outside the letter ranges and just above the digits ends up empty
        add_row(CMD_QUERY, 8'h40, 1'b0, 1'b0, 1'b0, 0, 0, 1'b0, 1'b0);
        add_row(CMD_QUERY, 8'h5B, 1'b0, 1'b0, 1'b0, 0, 0, 1'b0, 1'b0);
        add_row(CMD_QUERY, 8'h60, 1'b0, 1'b0, 1'b0, 0, 0, 1'b0, 1'b0);
        add_row(CMD_QUERY, 8'h7B, 1'b0, 1'b0, 1'b0, 0, 0, 1'b0, 1'b0);
        add_row(CMD_QUERY, 8'h3A, 1'b1, 1'b0, 1'b0, 0, 0, 1'b0, 1'b0);
        add_row(CMD_CAND,  8'h39, 1'b1, 1'b0, 1'b1, 1, 0, 1'b0, 1'b0);

        // reset, held once at the start
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[r])
        begin
            send_beat(directed_rows[r].beat, directed_rows[r].fixed, directed_rows[r].score);
        end

        for (p = 0; p < 6; p++)
        begin
            set_threshold(phase_thresholds[p]);
            run_phase(PHASE_BEATS);
        end

        settle(DRAIN_WAIT);
        if (mismatches == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // run limit, far beyond the slowest legal run
    initial
    begin : watchdog
        #50000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
